// File: rtl/pwlc_pkg.sv
// shared types, constants and breakpoint tables for the piecewise linear curve evaluator
// abscissas are signed Q20.12, ordinates unsigned Q9.31
// no dependencies
package pwlc_pkg;

    localparam int TABLE_POINTS       = 20;
    localparam int CURVES             = 4;
    localparam int CURVE_DEPTH        = 20;
    localparam int X_W                = 33;
    localparam int Y_W                = 40;
    localparam int SEG_W              = $clog2(CURVE_DEPTH);
    // widest segment is 10000 m in Q20.12
    localparam int SPAN_W             = 26;
    localparam int HALF_W             = Y_W / 2;
    localparam int PROD_W             = HALF_W + SPAN_W;
    localparam int NUM_W              = Y_W + SPAN_W;
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = Y_W / DIV_BITS_PER_STAGE;

    typedef logic signed [X_W-1:0] x_t;
    typedef logic [Y_W-1:0]        y_t;
    typedef logic [SEG_W-1:0]      seg_t;
    typedef logic [SPAN_W-1:0]     span_t;

    typedef enum logic [1:0] {
        CLAMP_NONE  = 2'd0,
        CLAMP_BELOW = 2'd1,
        CLAMP_ABOVE = 2'd2
    } clamp_t;

    // data that rides alongside the divider
    typedef struct packed {
        y_t     base;
        logic   neg;
        clamp_t status;
    } pwlc_side_t;

    // whole units to Q20.12
    function automatic x_t qa(input int m);
        logic signed [63:0] t;
        t = 64'(m) * 64'sd4096;
        return t[X_W-1:0];
    endfunction

    // hundredths to Q20.12, round half up
    function automatic x_t qm(input int h);
        logic signed [63:0] t;
        t = (64'(h) * 64'sd4096 + 64'sd50) / 64'sd100;
        return t[X_W-1:0];
    endfunction

    // value scaled by 1e7 to Q9.31, round half up
    function automatic y_t qy(input longint unsigned d);
        logic [63:0] t;
        t = (d * 64'd2147483648 + 64'd5000000) / 64'd10000000;
        return t[Y_W-1:0];
    endfunction

    // whole units to Q9.31
    function automatic y_t qw(input int unsigned n);
        logic [63:0] t;
        t = 64'(n) << 31;
        return t[Y_W-1:0];
    endfunction

    function automatic seg_t last_idx(input int own);
        int n;
        n = own;
        if (n > TABLE_POINTS)
            n = TABLE_POINTS;
        if (n > CURVE_DEPTH)
            n = CURVE_DEPTH;
        if (n < 1)
            n = 1;
        return seg_t'(n - 1);
    endfunction

    localparam seg_t LAST_IDX [CURVES] = '{last_idx(14), last_idx(20), last_idx(20),
                                           last_idx(17)};

    localparam x_t X_TAB [CURVES][CURVE_DEPTH] = '{
        '{qa(0), qa(1000), qa(2000), qa(3000), qa(4000), qa(5000), qa(6000), qa(7000),
          qa(8000), qa(9000), qa(10000), qa(15000), qa(20000), qa(25000),
          '0, '0, '0, '0, '0, '0},
        '{qa(0), qa(1000), qa(2000), qa(3000), qa(4000), qa(5000), qa(6000), qa(7000),
          qa(8000), qa(9000), qa(10000), qa(15000), qa(20000), qa(25000), qa(30000),
          qa(40000), qa(50000), qa(60000), qa(70000), qa(80000)},
        '{qa(0), qa(1000), qa(2000), qa(3000), qa(4000), qa(5000), qa(6000), qa(7000),
          qa(8000), qa(9000), qa(10000), qa(15000), qa(20000), qa(25000), qa(30000),
          qa(40000), qa(50000), qa(60000), qa(70000), qa(80000)},
        '{qm(0), qm(30), qm(50), qm(70), qm(89), qm(92), qm(96), qm(98), qm(100),
          qm(102), qm(106), qm(124), qm(153), qm(199), qm(287), qm(289), qm(500),
          '0, '0, '0}
    };

    localparam y_t Y_TAB [CURVES][CURVE_DEPTH] = '{
        '{qy(98070000), qy(98040000), qy(98010000), qy(97970000), qy(97940000),
          qy(97910000), qy(97880000), qy(97850000), qy(97820000), qy(97790000),
          qy(97760000), qy(97610000), qy(97450000), qy(97300000),
          '0, '0, '0, '0, '0, '0},
        '{qy(12250000), qy(11120000), qy(10070000), qy(9093000), qy(8194000),
          qy(7364000), qy(6601000), qy(5900000), qy(5258000), qy(4671000),
          qy(4135000), qy(1948000), qy(889100), qy(400800), qy(184100),
          qy(39960), qy(10270), qy(3097), qy(828), qy(185)},
        '{qw(340), qw(336), qw(332), qw(328), qw(324), qw(320), qw(316), qw(312),
          qw(308), qw(303), qw(299), qw(295), qw(295), qw(295), qw(305), qw(324),
          qw(337), qw(319), qw(289), qw(269)},
        '{qy(0), qy(1629000), qy(1659000), qy(2031000), qy(2597000), qy(3010000),
          qy(3287000), qy(4002000), qy(4258000), qy(4335000), qy(4483000),
          qy(4064000), qy(3663000), qy(2897000), qy(2297000), qy(2306000),
          qy(2656000), '0, '0, '0}
    };

endpackage

// File: rtl/piecewise_linear_curve_eval.sv
// piecewise linear curve evaluator: segment search, interpolation, pipelined divide
// stages: segment search, table fetch, partial products, numerator with rounding,
// 10 divider stages, output register
// throughput: one item per cycle; busy stays low, the pipeline never stalls
// reset clears all valid bits; items in flight at reset are dropped
// depends on pwlc_pkg and pwlc_div
module piecewise_linear_curve_eval
    import pwlc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] command,
    input  x_t         x_value,
    output logic       done,
    output y_t         y_value,
    output logic [1:0] clamp_status
);

    localparam int LATENCY = DIV_STAGES + 5;

    logic in_xfer;

    // stage 1: segment search
    logic       s1_valid_reg;
    logic [1:0] s1_cmd_reg;
    seg_t       s1_seg_reg;
    clamp_t     s1_status_reg;
    x_t         s1_x_reg;
    seg_t       s1_seg_next;
    clamp_t     s1_status_next;

    // stage 2: table fetch and differences
    logic       s2_valid_reg;
    pwlc_side_t s2_side_reg;
    y_t         s2_mag_reg;
    span_t      s2_dx_reg;
    span_t      s2_span_reg;
    pwlc_side_t s2_side_next;
    y_t         s2_mag_next;
    span_t      s2_dx_next;
    span_t      s2_span_next;

    // stage 3: partial products
    logic              s3_valid_reg;
    pwlc_side_t        s3_side_reg;
    logic [PROD_W-1:0] s3_lo_reg;
    logic [PROD_W-1:0] s3_hi_reg;
    span_t             s3_span_reg;

    // stage 4: numerator with half-span rounding
    logic             s4_valid_reg;
    pwlc_side_t       s4_side_reg;
    logic [NUM_W-1:0] s4_num_reg;
    span_t            s4_span_reg;
    logic [NUM_W-1:0] s4_num_next;

    logic       div_valid;
    y_t         div_quot;
    pwlc_side_t div_side;

    logic   done_reg;
    y_t     y_value_reg;
    clamp_t clamp_status_reg;
    y_t     y_value_next;

    assign busy    = 1'b0;
    assign in_xfer = start && !busy;

    always_comb
    begin
        logic found;
        found       = 1'b0;
        s1_seg_next = '0;
        for (int i = 0; i < CURVE_DEPTH - 1; i++)
        begin
            if (!found && (i + 1 <= int'(LAST_IDX[command])) &&
                (x_value <= X_TAB[command][i+1]))
            begin
                s1_seg_next = seg_t'(i);
                found       = 1'b1;
            end
        end
        if (x_value < X_TAB[command][0])
        begin
            s1_status_next = CLAMP_BELOW;
            s1_seg_next    = '0;
        end
        else if (x_value > X_TAB[command][LAST_IDX[command]])
        begin
            s1_status_next = CLAMP_ABOVE;
            s1_seg_next    = '0;
        end
        else
        begin
            s1_status_next = CLAMP_NONE;
        end
    end

    always_comb
    begin
        x_t   x0;
        x_t   x1;
        y_t   y0;
        y_t   y1;
        x_t   span_full;
        x_t   dx_full;
        seg_t seg_hi;
        seg_hi    = seg_t'(s1_seg_reg + 1'b1);
        x0        = X_TAB[s1_cmd_reg][s1_seg_reg];
        x1        = X_TAB[s1_cmd_reg][seg_hi];
        y0        = Y_TAB[s1_cmd_reg][s1_seg_reg];
        y1        = Y_TAB[s1_cmd_reg][seg_hi];
        span_full = x1 - x0;
        dx_full   = s1_x_reg - x0;
        s2_span_next        = span_full[SPAN_W-1:0];
        s2_side_next.status = s1_status_reg;
        case (s1_status_reg)
            CLAMP_NONE:
            begin
                s2_side_next.base = y0;
                s2_side_next.neg  = (y1 < y0);
                s2_mag_next       = (y1 < y0) ? (y0 - y1) : (y1 - y0);
                s2_dx_next        = dx_full[SPAN_W-1:0];
            end
            CLAMP_ABOVE:
            begin
                s2_side_next.base = Y_TAB[s1_cmd_reg][LAST_IDX[s1_cmd_reg]];
                s2_side_next.neg  = 1'b0;
                s2_mag_next       = '0;
                s2_dx_next        = '0;
            end
            default:
            begin
                s2_side_next.base = Y_TAB[s1_cmd_reg][0];
                s2_side_next.neg  = 1'b0;
                s2_mag_next       = '0;
                s2_dx_next        = '0;
            end
        endcase
    end

    assign s4_num_next = (NUM_W'(s3_hi_reg) << HALF_W) + NUM_W'(s3_lo_reg)
                       + NUM_W'(s3_span_reg >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_xfer;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg    <= command;
        s1_seg_reg    <= s1_seg_next;
        s1_status_reg <= s1_status_next;
        s1_x_reg      <= x_value;

        s2_side_reg <= s2_side_next;
        s2_mag_reg  <= s2_mag_next;
        s2_dx_reg   <= s2_dx_next;
        s2_span_reg <= s2_span_next;

        s3_side_reg <= s2_side_reg;
        s3_lo_reg   <= PROD_W'(s2_mag_reg[HALF_W-1:0]) * PROD_W'(s2_dx_reg);
        s3_hi_reg   <= PROD_W'(s2_mag_reg[Y_W-1:HALF_W]) * PROD_W'(s2_dx_reg);
        s3_span_reg <= s2_span_reg;

        s4_side_reg <= s3_side_reg;
        s4_num_reg  <= s4_num_next;
        s4_span_reg <= s3_span_reg;

        y_value_reg      <= y_value_next;
        clamp_status_reg <= div_side.status;
    end

    pwlc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .num       (s4_num_reg),
        .span      (s4_span_reg),
        .in_side   (s4_side_reg),
        .out_valid (div_valid),
        .quot      (div_quot),
        .out_side  (div_side)
    );

    // result stays between the two ordinates, so no wrap
    assign y_value_next = div_side.neg ? (div_side.base - div_quot)
                                       : (div_side.base + div_quot);

    assign done         = done_reg;
    assign y_value      = y_value_reg;
    assign clamp_status = clamp_status_reg;

    ap_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> ##LATENCY done)
        else $error("start transfer without result");

    ap_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_xfer, LATENCY))
        else $error("result without start transfer");

    ap_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_status_reg == CLAMP_NONE) |-> (s1_seg_reg < LAST_IDX[s1_cmd_reg]))
        else $error("segment index past last breakpoint");

endmodule

// File: rtl/pwlc_div.sv
// pipelined restoring divider with rounding offset already in the numerator
// quotient of NUM_W-bit numerator by SPAN_W-bit span, DIV_BITS_PER_STAGE bits per stage
// depends on pwlc_pkg
module pwlc_div
    import pwlc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  span_t            span,
    input  pwlc_side_t       in_side,
    output logic             out_valid,
    output y_t               quot,
    output pwlc_side_t       out_side
);

    // work word: remainder on top, numerator bits below, quotient bits shift in at the bottom
    logic             valid_reg [DIV_STAGES];
    logic [NUM_W-1:0] work_reg  [DIV_STAGES];
    span_t            span_reg  [DIV_STAGES];
    pwlc_side_t       side_reg  [DIV_STAGES];

    logic             stage_valid [DIV_STAGES];
    logic [NUM_W-1:0] stage_work  [DIV_STAGES];
    span_t            stage_span  [DIV_STAGES];
    pwlc_side_t       stage_side  [DIV_STAGES];
    logic [NUM_W-1:0] work_next   [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_head
            assign stage_valid[k] = in_valid;
            assign stage_work[k]  = num;
            assign stage_span[k]  = span;
            assign stage_side[k]  = in_side;
        end else begin : g_body
            assign stage_valid[k] = valid_reg[k-1];
            assign stage_work[k]  = work_reg[k-1];
            assign stage_span[k]  = span_reg[k-1];
            assign stage_side[k]  = side_reg[k-1];
        end

        always_comb
        begin
            logic [NUM_W-1:0] w;
            logic [SPAN_W:0]  trial;
            logic [SPAN_W:0]  diff;
            w = stage_work[k];
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++)
            begin
                trial = {w[NUM_W-1:Y_W], w[Y_W-1]};
                diff  = trial - {1'b0, stage_span[k]};
                if (trial >= {1'b0, stage_span[k]})
                begin
                    w = {diff[SPAN_W-1:0], w[Y_W-2:0], 1'b1};
                end
                else
                begin
                    w = {trial[SPAN_W-1:0], w[Y_W-2:0], 1'b0};
                end
            end
            work_next[k] = w;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= stage_valid[k];
        end

        always_ff @(posedge clk)
        begin
            work_reg[k] <= work_next[k];
            span_reg[k] <= stage_span[k];
            side_reg[k] <= stage_side[k];
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign quot      = work_reg[DIV_STAGES-1][Y_W-1:0];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule
